// ----- rtl/core/mt19937_word_generator_assert.svh -----
// Assertion macros used by the checker file (mtwg_checker.sv).
`ifndef MT19937_WORD_GENERATOR_ASSERT_SVH
`define MT19937_WORD_GENERATOR_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define MTWG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mtwg assertion failed");

// Next-cycle implication, held off during reset.
`define MTWG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mtwg assertion failed");

`endif

// ----- rtl/core/mtwg_pkg.sv -----
`default_nettype none
package mtwg_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int IDX_W        = $clog2(STATE_WORDS + 2);
  localparam int FAR_WRAP     = STATE_WORDS - TWIST_OFFSET;

  localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
  localparam logic [31:0] SEED_MULT    = 32'd1812433253;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [31:0] SEED_RESET   = 32'd5489;

  localparam logic [IDX_W-1:0] IDX_FULL     = IDX_W'(STATE_WORDS);
  localparam logic [IDX_W-1:0] IDX_UNSEEDED = IDX_W'(STATE_WORDS + 1);
  localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(STATE_WORDS - 1);

  // Output tempering
  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/mt19937_word_generator.sv -----
`default_nettype none
// Channel   Direction  Signals                        Notes
// in        input      in_valid, in_ready, reseed     one draw request per transfer
// out       output     out_valid, out_ready,          one tempered word per request
//                      random_word
// seed      input      seed_we, seed_wdata            seed register, reset 5489
//
// A plain draw goes through a table read, then tempering, before out_valid.
// A draw that empties the table adds a twist pass (one word per cycle over the two
// read ports of the table memory); a reseed adds a seeding pass (one word per cycle
// through the seeding multiplier) ahead of the twist. The first draw after reset
// always seeds. in_ready is high only while no request is in progress; a held
// result stalls the next word in the tempering step until out_ready.
module mt19937_word_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        reseed,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      random_word,
  input  wire logic        seed_we,
  input  wire logic [31:0] seed_wdata
);
  import mtwg_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SEED   = 6'b000010,
    ST_PRIME  = 6'b000100,
    ST_TWIST  = 6'b001000,
    ST_READ   = 6'b010000,
    ST_TEMPER = 6'b100000
  } state_t;

  localparam int ADDR_W = $clog2(STATE_WORDS);

  state_t            state;
  logic [IDX_W-1:0]  read_index;
  logic [IDX_W-1:0]  count;
  logic              pend_valid;
  logic [IDX_W-1:0]  pend_k;
  logic [31:0]       seed_reg;
  logic [31:0]       prev;
  logic [31:0]       cur;

  // table memory: one write port, two registered read ports
  logic [31:0]       table_mem [STATE_WORDS];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [31:0]       mem_wdata;
  logic [ADDR_W-1:0] raddr_a;
  logic [ADDR_W-1:0] raddr_b;
  logic [31:0]       rd_a;
  logic [31:0]       rd_b;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rd_a <= table_mem[raddr_a];
    rd_b <= table_mem[raddr_b];
  end

  // seeding recurrence
  logic [31:0] seed_mix;
  logic [31:0] seed_word;
  always_comb begin
    seed_mix  = prev ^ (prev >> 30);
    seed_word = (count == '0) ? seed_reg
                              : (SEED_MULT * seed_mix) + {{(32-IDX_W){1'b0}}, count};
  end

  // twist of one word, from the reads issued in the cycle before
  logic [31:0] tw_y;
  logic [31:0] tw_word;
  always_comb begin
    tw_y    = (cur & HIGH_BIT) | (rd_a & LOW_BITS);
    tw_word = rd_b ^ (tw_y >> 1) ^ (tw_y[0] ? TWIST_MATRIX : 32'h0);
  end

  // read addresses: successor and far word of the issued index, or the draw index
  logic [IDX_W-1:0] next_k;
  logic [IDX_W-1:0] far_k;
  always_comb begin
    next_k = (count >= IDX_LAST) ? '0 : count + 1'b1;
    far_k  = (count >= IDX_W'(FAR_WRAP)) ? count - IDX_W'(FAR_WRAP)
                                         : count + IDX_W'(TWIST_OFFSET);
    case (state)
      ST_PRIME:            raddr_a = '0;
      ST_TWIST:            raddr_a = next_k[ADDR_W-1:0];
      ST_READ, ST_TEMPER:  raddr_a = read_index[ADDR_W-1:0];
      default:             raddr_a = '0;
    endcase
    raddr_b = far_k[ADDR_W-1:0];
  end

  // write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[ADDR_W-1:0];
    mem_wdata = seed_word;
    case (state)
      ST_SEED: begin
        mem_we = 1'b1;
      end
      ST_TWIST: begin
        mem_we    = pend_valid;
        mem_waddr = pend_k[ADDR_W-1:0];
        mem_wdata = tw_word;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  // seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_reg <= SEED_RESET;
    end else if (seed_we) begin
      seed_reg <= seed_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      read_index <= IDX_UNSEEDED;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // tempering step refills the output itself
      if (out_valid && out_ready && (state != ST_TEMPER)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          count      <= '0;
          pend_valid <= 1'b0;
          if (in_valid) begin
            if (reseed || (read_index > IDX_FULL)) begin
              state <= ST_SEED;
            end else if (read_index == IDX_FULL) begin
              state <= ST_PRIME;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_SEED: begin
          if (count == IDX_LAST) begin
            count      <= '0;
            read_index <= IDX_FULL;
            state      <= ST_PRIME;
          end else begin
            count <= count + 1'b1;
          end
        end
        ST_PRIME: begin
          count      <= '0;
          pend_valid <= 1'b0;
          state      <= ST_TWIST;
        end
        ST_TWIST: begin
          if (count != IDX_FULL) begin
            count      <= count + 1'b1;
            pend_valid <= 1'b1;
            pend_k     <= count;
          end else begin
            pend_valid <= 1'b0;
          end
          if (pend_valid && (pend_k == IDX_LAST)) begin
            read_index <= '0;
            state      <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_TEMPER;
        end
        ST_TEMPER: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            read_index <= read_index + 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_SEED) begin
      prev <= seed_word;
    end
    if (state == ST_TWIST) begin
      cur <= rd_a;
    end
    if ((state == ST_TEMPER) && (!out_valid || out_ready)) begin
      random_word <= temper(rd_a);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/mtwg_checker.sv -----
`default_nettype none
`include "mt19937_word_generator_assert.svh"
module mtwg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] random_word
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] outstanding;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // requests taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + {1'b0, in_xfer} - {1'b0, out_xfer};
    end
  end

  // held result keeps its word
  `MTWG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(random_word))
  // one request in work at a time
  `MTWG_ASSERT_NEXT(a_one_in_work, in_xfer, !in_ready)
  // no result without a request
  `MTWG_ASSERT_NOW(a_no_orphan, out_valid, outstanding != 2'd0)
  // at most one waiting result and one in work
  `MTWG_ASSERT_NOW(a_bounded, 1'b1, outstanding != 2'd3)

endmodule

bind mt19937_word_generator mtwg_checker u_mtwg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .random_word (random_word)
);
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import mtwg_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 250;
  localparam int TAIL_CYCLES = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic reseed = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] random_word;
  logic seed_we = 1'b0;
  logic [31:0] seed_wdata = '0;

  mt19937_word_generator u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .reseed      (reseed),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .random_word (random_word),
    .seed_we     (seed_we),
    .seed_wdata  (seed_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Shadow generator state
  logic [31:0] mt_table [STATE_WORDS];
  logic [IDX_W-1:0] mt_pos = IDX_UNSEEDED;
  logic [31:0] mt_seed = SEED_RESET;

  logic [31:0] word_q [$];
  int fail_count = 0;
  int draws = 0;
  int reseeds = 0;
  int seed_writes = 0;
  int refills = 0;
  int words_checked = 0;

  // Idle shaping, changed per phase
  int gap_pct = 0;
  int stall_pct = 0;
  bit quiet = 1'b0;

  // Directed stimulus table
  typedef struct packed {
    bit load;
    logic [31:0] seed;
    bit rs;
    bit known;
    logic [31:0] word;
  } dir_row_t;

  dir_row_t dir_rows [15] = '{
    // first draw after reset seeds from the reset seed
    '{1'b0, 32'h0, 1'b0, 1'b1, 32'hd091_bb5c},
    '{1'b0, 32'h0, 1'b0, 1'b1, 32'h22ae_9ef6},
    '{1'b0, 32'h0, 1'b0, 1'b1, 32'he7e1_faee},
    // reseed with the reset seed restarts the sequence
    '{1'b0, 32'h0, 1'b1, 1'b1, 32'hd091_bb5c},
    // seed write alone does not disturb the running sequence
    '{1'b1, 32'hffff_ffff, 1'b0, 1'b1, 32'h22ae_9ef6},
    '{1'b0, 32'h0, 1'b1, 1'b0, 32'h0},
    '{1'b0, 32'h0, 1'b0, 1'b0, 32'h0},
    '{1'b1, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
    '{1'b0, 32'h0, 1'b0, 1'b0, 32'h0},
    '{1'b1, 32'h8000_0000, 1'b1, 1'b0, 32'h0},
    '{1'b1, 32'h0000_0001, 1'b1, 1'b0, 32'h0},
    '{1'b1, 32'd5489, 1'b0, 1'b0, 32'h0},
    // back-to-back reseeds
    '{1'b0, 32'h0, 1'b1, 1'b1, 32'hd091_bb5c},
    '{1'b0, 32'h0, 1'b1, 1'b1, 32'hd091_bb5c},
    '{1'b0, 32'h0, 1'b0, 1'b1, 32'h22ae_9ef6}
  };

  function automatic logic [31:0] tempered(input logic [31:0] raw);
    logic [31:0] t;
    t = raw ^ (raw >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    return t ^ (t >> 18);
  endfunction

  // Advance the shadow generator by one draw
  task automatic predict_word(input bit rs, output logic [31:0] w);
    logic [31:0] p;
    logic [31:0] y;
    int nxt;
    int far_k;
    if (rs || mt_pos > IDX_FULL) begin
      mt_table[0] = mt_seed;
      for (int i = 1; i < STATE_WORDS; i++) begin
        p = mt_table[i-1];
        mt_table[i] = SEED_MULT * (p ^ (p >> 30)) + 32'(i);
      end
      mt_pos = IDX_FULL;
    end
    if (mt_pos >= IDX_FULL) begin
      for (int k = 0; k < STATE_WORDS; k++) begin
        nxt = (k + 1) % STATE_WORDS;
        far_k = (k + TWIST_OFFSET) % STATE_WORDS;
        y = (mt_table[k] & HIGH_BIT) | (mt_table[nxt] & LOW_BITS);
        mt_table[k] = mt_table[far_k] ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'h0);
      end
      mt_pos = '0;
      refills++;
    end
    w = tempered(mt_table[mt_pos]);
    mt_pos = mt_pos + 1'b1;
  endtask

  // Present one request; expectation is taken at the transfer
  task automatic draw(input bit rs, input bit known, input logic [31:0] typed);
    logic [31:0] w;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    reseed <= rs;
    do @(posedge clk); while (!in_ready);
    predict_word(rs, w);
    word_q.push_back(known ? typed : w);
    draws++;
    if (rs) reseeds++;
  endtask

  // Seed register write, only once all words are out
  task automatic load_seed(input logic [31:0] v);
    in_valid <= 1'b0;
    while (word_q.size() != 0) @(posedge clk);
    seed_we <= 1'b1;
    seed_wdata <= v;
    @(posedge clk);
    mt_seed = v;
    seed_we <= 1'b0;
    seed_writes++;
  endtask

  // Output backpressure in bursts of random length
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each output transfer with the oldest expected word
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (word_q.size() == 0) begin
        $error("random_word: unexpected transfer, got %h", random_word);
        fail_count++;
      end else begin
        if (random_word !== word_q[0]) begin
          $error("random_word mismatch: expected %h, got %h", word_q[0], random_word);
          fail_count++;
        end
        void'(word_q.pop_front());
        words_checked++;
      end
    end
  end

  // Watchdog on cycles without any transfer
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", WATCHDOG_LIMIT);
      $display("mt19937_word_generator regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Per-phase shaping for the random part
  int phase_reseed_pct [PHASES] = '{0, 0, 0, 3, 30, 1, 0, 5};
  int phase_gap_pct [PHASES] = '{30, 0, 50, 20, 10, 40, 15, 0};
  int phase_stall_pct [PHASES] = '{20, 40, 0, 30, 10, 50, 0, 0};

  initial begin
    logic [31:0] s;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    gap_pct = 25;
    stall_pct = 25;
    foreach (dir_rows[r]) begin
      if (dir_rows[r].load) load_seed(dir_rows[r].seed);
      draw(dir_rows[r].rs, dir_rows[r].known, dir_rows[r].word);
    end

    // random phases, each with its own seed; the last one runs without idling
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: s = 32'h0000_0000;
        1: s = 32'hffff_ffff;
        default: s = $urandom;
      endcase
      load_seed(s);
      gap_pct = phase_gap_pct[ph];
      stall_pct = phase_stall_pct[ph];
      quiet = (ph == PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 0 && ph != 0) begin
          draw(1'($urandom_range(0, 1)), 1'b0, '0);
        end else begin
          draw($urandom_range(0, 99) < phase_reseed_pct[ph], 1'b0, '0);
        end
      end
    end

    // drain
    in_valid <= 1'b0;
    while (word_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d draws (%0d reseeding), %0d seed writes, %0d table twists",
             draws, reseeds, seed_writes, refills);
    $display("%0d words compared, %0d mismatches", words_checked, fail_count);
    if (fail_count == 0 && word_q.size() == 0) begin
      $display("mt19937_word_generator regression: pass");
    end else begin
      $display("mt19937_word_generator regression: fail");
    end
    $finish;
  end

endmodule
